>>> rtl/hsv_pkg.sv
// Shared types and constants for the HSV to RGB converter.
package hsv_pkg;

  // Field widths
  localparam int unsigned HUE_W  = 14;
  localparam int unsigned PCT_W  = 12;
  localparam int unsigned CHAN_W = 8;

  // Pipeline depth
  localparam int unsigned NUM_STG = 7;

  // Clamped value widths
  localparam int unsigned HC_W   = 13;   // clamped hue, 0..5760
  localparam int unsigned PC_W   = 11;   // clamped percent, 0..1600
  localparam int unsigned HM_W   = 11;   // hue mod 1920
  localparam int unsigned DIST_W = 10;   // 0..960
  localparam int unsigned TERM_W = 21;   // 1536000 - s*d
  localparam int unsigned NUM_W  = 32;   // v * term
  localparam int unsigned QT_W   = 18;   // (17*num) >> 18

  // Ranges in input units
  localparam logic [HC_W-1:0] HUE_MAX  = 13'd5760;
  localparam logic [PC_W-1:0] PCT_MAX  = 11'd1600;
  localparam logic [HC_W-1:0] HALF_SECT = 13'd960;
  localparam logic [HC_W-1:0] FULL_SECT = 13'd1920;

  // Channel scale: 255/(1600*1600*960) = 17/(2^18 * 625)
  localparam logic [TERM_W-1:0] TERM_FULL = 21'd1536000;  // 960*1600
  localparam logic [4:0]        SCALE_MUL = 5'd17;
  localparam int unsigned       SCALE_SHR = 18;
  localparam logic [9:0]        DIV_C     = 10'd625;
  localparam logic [14:0]       DIV_RECIP = 15'd26843;    // floor(2^24/625)
  localparam int unsigned       RECIP_SHR = 24;

  // Hue sectors, 60 degrees each
  typedef enum logic [2:0] {
    SECT_RY, SECT_YG, SECT_GC, SECT_CB, SECT_BM, SECT_MR
  } hsv_sector_e;

  // Stage advance strobes for the channel back end
  typedef struct packed {
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } hsv_adv_t;

endpackage

>>> rtl/hsv_if.sv
// Valid/ready channel interfaces for HSV input and RGB output words.
interface hsv_pix_if;
  import hsv_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [HUE_W-1:0]  hue;
  logic signed [PCT_W-1:0]  saturation;
  logic signed [PCT_W-1:0]  brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv_rgb_if;
  import hsv_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> rtl/hsv_chan.sv
// One color channel back end: v*term, scale by 17/2^18, divide by 625.
module hsv_chan (
  input  logic                        clk_i,
  input  hsv_pkg::hsv_adv_t           adv_i,
  input  logic [hsv_pkg::TERM_W-1:0]  term_i,
  input  logic [hsv_pkg::PC_W-1:0]    bri_i,
  output logic [hsv_pkg::CHAN_W-1:0]  chan_o
);
  import hsv_pkg::*;

  logic [NUM_W-1:0]      num_q, num_d;
  logic [QT_W-1:0]       qt_q, qt_d, qt6_q;
  logic [CHAN_W-1:0]     est_q, est_d;
  logic [CHAN_W-1:0]     chan_q, chan_d;
  logic [NUM_W+4:0]      scaled;
  logic [QT_W+14:0]      recip_prod;
  logic [QT_W-1:0]       rem;

  // Stage 4: numerator over the common denominator
  assign num_d = NUM_W'(bri_i) * NUM_W'(term_i);

  // Stage 5: times 17, drop 2^18
  assign scaled = (NUM_W+5)'(num_q) * (NUM_W+5)'(SCALE_MUL);
  assign qt_d   = QT_W'(scaled >> SCALE_SHR);

  // Stage 6: reciprocal estimate of qt/625, low by at most one
  assign recip_prod = (QT_W+15)'(qt_q) * (QT_W+15)'(DIV_RECIP);
  assign est_d      = CHAN_W'(recip_prod >> RECIP_SHR);

  // Stage 7: remainder check fixes the estimate
  assign rem = qt6_q - QT_W'(est_q) * QT_W'(DIV_C);
  always_comb begin
    chan_d = est_q;
    if (rem >= QT_W'(DIV_C)) begin
      chan_d = est_q + CHAN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) num_q <= num_d;
    if (adv_i.s5) qt_q  <= qt_d;
    if (adv_i.s6) begin
      est_q <= est_d;
      qt6_q <= qt_q;
    end
    if (adv_i.s7) chan_q <= chan_d;
  end

  assign chan_o = chan_q;

endmodule

>>> rtl/hsv_to_rgb_convert.sv
// Top level: pipelined HSV to 8-bit RGB pixel converter.
//
//   channel | dir | fields                        | handshake
//   pix_i   | in  | hue, saturation, brightness   | valid/ready
//   rgb_o   | out | red, green, blue              | valid/ready
//
// Seven register stages: one word enters per cycle unless back-pressure
// from the output holds the stages full. Stages 4..7 sit in one channel unit per
// color; the widest step is the 11x21 product in stage 4.
// rst_ni clears only the stage valid bits; data registers are not reset.
// Each stage holds while it is full and the stage after it cannot take,
// so empty stages still fill while the output waits.
module hsv_to_rgb_convert (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsv_pix_if.sink    pix_i,
  hsv_rgb_if.source  rgb_o
);
  import hsv_pkg::*;

  logic [NUM_STG:1] vld_q;
  logic [NUM_STG:1] rdy;

  // Stage 1 regs
  logic [HC_W-1:0]   h1_q, h1_d;
  logic [PC_W-1:0]   s1_q, s1_d, v1_q, v1_d;
  // Stage 2 regs
  hsv_sector_e       sec2_q, sec2_d;
  logic [DIST_W-1:0] dist2_q, dist2_d;
  logic [PC_W-1:0]   s2_q, v2_q;
  // Stage 3 regs
  logic [TERM_W-1:0] tr3_q, tg3_q, tb3_q, tr3_d, tg3_d, tb3_d;
  logic [PC_W-1:0]   v3_q;

  logic [HM_W-1:0]   hm;
  logic [DIST_W-1:0] dr, dg, db;
  hsv_adv_t          adv;

  // Ready chain from the output back
  always_comb begin
    rdy[NUM_STG] = !vld_q[NUM_STG] || rgb_o.ready;
    for (int i = NUM_STG-1; i >= 1; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  assign pix_i.ready = rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[1]) vld_q[1] <= pix_i.valid;
      for (int i = 2; i <= NUM_STG; i++) begin
        if (rdy[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Stage 1: clamp inputs
  always_comb begin
    if (pix_i.hue < 0) begin
      h1_d = '0;
    end else if (pix_i.hue > $signed({1'b0, HUE_MAX})) begin
      h1_d = HUE_MAX;
    end else begin
      h1_d = pix_i.hue[HC_W-1:0];
    end
    if (pix_i.saturation < 0) begin
      s1_d = '0;
    end else if (pix_i.saturation > $signed({1'b0, PCT_MAX})) begin
      s1_d = PCT_MAX;
    end else begin
      s1_d = pix_i.saturation[PC_W-1:0];
    end
    if (pix_i.brightness < 0) begin
      v1_d = '0;
    end else if (pix_i.brightness > $signed({1'b0, PCT_MAX})) begin
      v1_d = PCT_MAX;
    end else begin
      v1_d = pix_i.brightness[PC_W-1:0];
    end
  end

  // Stage 2: sector, hue mod 120 degrees, distance from the middle of that 120-degree span
  always_comb begin
    if (h1_q < HALF_SECT) begin
      sec2_d = SECT_RY;
    end else if (h1_q < FULL_SECT) begin
      sec2_d = SECT_YG;
    end else if (h1_q < FULL_SECT + HALF_SECT) begin
      sec2_d = SECT_GC;
    end else if (h1_q < 13'(2 * FULL_SECT)) begin
      sec2_d = SECT_CB;
    end else if (h1_q < 13'(2 * FULL_SECT) + HALF_SECT) begin
      sec2_d = SECT_BM;
    end else begin
      sec2_d = SECT_MR;
    end

    if (h1_q < FULL_SECT) begin
      hm = HM_W'(h1_q);
    end else if (h1_q < 13'(2 * FULL_SECT)) begin
      hm = HM_W'(h1_q - FULL_SECT);
    end else if (h1_q < HUE_MAX) begin
      hm = HM_W'(h1_q - 13'(2 * FULL_SECT));
    end else begin
      hm = '0;
    end

    if (hm >= HM_W'(HALF_SECT)) begin
      dist2_d = DIST_W'(hm - HM_W'(HALF_SECT));
    end else begin
      dist2_d = DIST_W'(HM_W'(HALF_SECT) - hm);
    end
  end

  // Stage 3: per channel d is 0 for C, dist for X, 960 for zero;
  // term = 960*1600 - s*d
  always_comb begin
    case (sec2_q)
      SECT_RY: begin dr = '0;      dg = dist2_q;           db = DIST_W'(HALF_SECT); end
      SECT_YG: begin dr = dist2_q; dg = '0;                db = DIST_W'(HALF_SECT); end
      SECT_GC: begin dr = DIST_W'(HALF_SECT); dg = '0;     db = dist2_q;            end
      SECT_CB: begin dr = DIST_W'(HALF_SECT); dg = dist2_q; db = '0;                end
      SECT_BM: begin dr = dist2_q; dg = DIST_W'(HALF_SECT); db = '0;                end
      SECT_MR: begin dr = '0;      dg = DIST_W'(HALF_SECT); db = dist2_q;           end
      default: begin dr = '0;      dg = '0;                db = '0;                 end
    endcase
    tr3_d = TERM_FULL - TERM_W'(s2_q) * TERM_W'(dr);
    tg3_d = TERM_FULL - TERM_W'(s2_q) * TERM_W'(dg);
    tb3_d = TERM_FULL - TERM_W'(s2_q) * TERM_W'(db);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      h1_q <= h1_d;
      s1_q <= s1_d;
      v1_q <= v1_d;
    end
    if (rdy[2]) begin
      sec2_q  <= sec2_d;
      dist2_q <= dist2_d;
      s2_q    <= s1_q;
      v2_q    <= v1_q;
    end
    if (rdy[3]) begin
      tr3_q <= tr3_d;
      tg3_q <= tg3_d;
      tb3_q <= tb3_d;
      v3_q  <= v2_q;
    end
  end

  // Back end strobes
  assign adv.s4 = rdy[4];
  assign adv.s5 = rdy[5];
  assign adv.s6 = rdy[6];
  assign adv.s7 = rdy[7];

  hsv_chan u_red (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .term_i (tr3_q),
    .bri_i  (v3_q),
    .chan_o (rgb_o.red)
  );

  hsv_chan u_green (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .term_i (tg3_q),
    .bri_i  (v3_q),
    .chan_o (rgb_o.green)
  );

  hsv_chan u_blue (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .term_i (tb3_q),
    .bri_i  (v3_q),
    .chan_o (rgb_o.blue)
  );

  assign rgb_o.valid = vld_q[NUM_STG];

endmodule

>>> verif/hsv_to_rgb_convert_checker.sv
// Checker for the HSV to RGB converter: predicts each pixel's color and compares it.
module hsv_to_rgb_convert_checker (
  input  logic clk_i,
  input  logic rst_ni,
  hsv_pix_if   pix,
  hsv_rgb_if   rgb,
  output int   fail_cnt_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import hsv_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_word_t;

  localparam longint unsigned HUE_TOP  = 5760;
  localparam longint unsigned PCT_TOP  = 1600;
  localparam longint unsigned HALF_DEG = 960;
  localparam longint unsigned FULL_DEG = 1920;
  localparam longint unsigned COMMON_D = PCT_TOP * PCT_TOP * HALF_DEG;

  rgb_word_t expected_rgb_q[$];
  int        mismatch_cnt;
  int        pend_cnt;

  // Scale one channel numerator to a byte, truncating once
  function automatic logic [CHAN_W-1:0] scale_to_byte(longint unsigned num);
    longint unsigned q;
    q = (num * 255) / COMMON_D;
    if (q > 255) q = 255;
    return q[CHAN_W-1:0];
  endfunction

  // Exact HSV to RGB over the denominator 1600*1600*960
  function automatic rgb_word_t predict_rgb(logic signed [HUE_W-1:0] hue,
                                            logic signed [PCT_W-1:0] sat,
                                            logic signed [PCT_W-1:0] bri);
    longint unsigned h, s, v, hm, mid_gap, k, cn, xn, mn, r, g, b;
    hsv_sector_e     sect;
    rgb_word_t       res;
    // clamp to legal ranges
    if (hue < 0) h = 0;
    else if (hue > 5760) h = HUE_TOP;
    else h = longint'(hue);
    if (sat < 0) s = 0;
    else if (sat > 1600) s = PCT_TOP;
    else s = longint'(sat);
    if (bri < 0) v = 0;
    else if (bri > 1600) v = PCT_TOP;
    else v = longint'(bri);

    hm      = h % FULL_DEG;
    mid_gap = (hm >= HALF_DEG) ? hm - HALF_DEG : HALF_DEG - hm;
    k       = HALF_DEG - mid_gap;
    cn      = s * v * HALF_DEG;
    xn      = s * v * k;
    mn      = v * HALF_DEG * (PCT_TOP - s);

    // 360 degrees belongs to the last sector
    sect = (h >= HUE_TOP) ? SECT_MR : hsv_sector_e'(h / HALF_DEG);
    case (sect)
      SECT_RY: begin r = cn; g = xn; b = 0;  end
      SECT_YG: begin r = xn; g = cn; b = 0;  end
      SECT_GC: begin r = 0;  g = cn; b = xn; end
      SECT_CB: begin r = 0;  g = xn; b = cn; end
      SECT_BM: begin r = xn; g = 0;  b = cn; end
      default: begin r = cn; g = 0;  b = xn; end
    endcase

    res.red   = scale_to_byte(r + mn);
    res.green = scale_to_byte(g + mn);
    res.blue  = scale_to_byte(b + mn);
    return res;
  endfunction

  // Queue a prediction per accepted pixel, compare each accepted color word
  always @(posedge clk_i or negedge rst_ni) begin
    rgb_word_t exp_w;
    if (!rst_ni) begin
      expected_rgb_q.delete();
      mismatch_cnt = 0;
      pend_cnt     = 0;
    end else begin
      if (pix.valid && pix.ready)
        expected_rgb_q.push_back(predict_rgb(pix.hue, pix.saturation, pix.brightness));
      if (rgb.valid && rgb.ready) begin
        if (expected_rgb_q.size() == 0) begin
          $error("unexpected output word: red %0d green %0d blue %0d",
                 rgb.red, rgb.green, rgb.blue);
          mismatch_cnt++;
        end else begin
          exp_w = expected_rgb_q.pop_front();
          if (rgb.red !== exp_w.red) begin
            $error("red mismatch: expected %0d, actual %0d", exp_w.red, rgb.red);
            mismatch_cnt++;
          end
          if (rgb.green !== exp_w.green) begin
            $error("green mismatch: expected %0d, actual %0d", exp_w.green, rgb.green);
            mismatch_cnt++;
          end
          if (rgb.blue !== exp_w.blue) begin
            $error("blue mismatch: expected %0d, actual %0d", exp_w.blue, rgb.blue);
            mismatch_cnt++;
          end
        end
      end
      pend_cnt = expected_rgb_q.size();
    end
  end

  assign fail_cnt_o = mismatch_cnt;
  assign pending_o  = pend_cnt;

endmodule

>>> verif/hsv_to_rgb_convert_test.sv
// Testbench top for the HSV to RGB converter: clock, reset, stimulus and verdict.
module hsv_to_rgb_convert_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hsv_pkg::*;

  localparam int STALL_LIMIT = 1000;

  logic clk_i;
  logic rst_ni;
  int   fail_cnt;
  int   pending;
  int   send_idle;
  int   recv_stall;
  int   quiet_cycles;

  hsv_pix_if pix_if ();
  hsv_rgb_if rgb_if ();

  hsv_to_rgb_convert DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .rgb_o  (rgb_if)
  );

  hsv_to_rgb_convert_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix        (pix_if),
    .rgb        (rgb_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Output back-pressure
  always @(posedge clk_i) begin
    rgb_if.ready <= ($urandom_range(99) >= recv_stall);
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (rgb_if.valid && rgb_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one pixel after a random gap, hold it until taken
  task automatic send_pixel(input int h, input int s, input int b);
    while ($urandom_range(99) < send_idle) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid      <= 1'b1;
    pix_if.hue        <= HUE_W'(h);
    pix_if.saturation <= PCT_W'(s);
    pix_if.brightness <= PCT_W'(b);
    do @(posedge clk_i); while (!pix_if.ready);
  endtask

  // Mostly legal pixels, some across the whole signed range
  task automatic send_random(input int count);
    int h, s, b;
    repeat (count) begin
      h = ($urandom_range(99) < 80) ? $urandom_range(0, 5760) : $urandom_range(0, 16383);
      s = ($urandom_range(99) < 80) ? $urandom_range(0, 1600) : $urandom_range(0, 4095);
      b = ($urandom_range(99) < 80) ? $urandom_range(0, 1600) : $urandom_range(0, 4095);
      send_pixel(h, s, b);
    end
  endtask

  // Hold the input low until every predicted word is out;
  // the count is read mid-cycle, after the checker has updated it
  task automatic drain;
    pix_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  initial begin
    pix_if.valid      = 1'b0;
    pix_if.hue        = '0;
    pix_if.saturation = '0;
    pix_if.brightness = '0;
    rgb_if.ready      = 1'b0;
    quiet_cycles      = 0;
    send_idle         = 0;
    recv_stall        = 0;
    rst_ni            = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: clamps, sector edges, 360 degrees, gray and black
    send_pixel(-8192, 1600, 1600);
    send_pixel(8191, 1600, 1600);
    send_pixel(5760, 1600, 1600);
    send_pixel(5761, 2047, 2047);
    send_pixel(0, -2048, -2048);
    send_pixel(1, 1600, 1600);
    send_pixel(959, 1600, 1600);
    send_pixel(960, 1600, 1600);
    send_pixel(1919, 1600, 1600);
    send_pixel(1920, 1600, 1600);
    send_pixel(2879, 1600, 1600);
    send_pixel(2880, 1600, 1600);
    send_pixel(3839, 1600, 1600);
    send_pixel(3840, 1600, 1600);
    send_pixel(4799, 1600, 1600);
    send_pixel(4800, 1600, 1600);
    send_pixel(5759, 1600, 1600);
    send_pixel(480, 0, 1600);
    send_pixel(480, 1600, 0);
    send_pixel(3000, 1601, 1601);
    send_pixel(2000, 800, 1200);
    send_pixel(-1, 2047, 1);
    send_pixel(5000, -1, 1599);
    send_pixel(4321, 1, 1600);

    // Random phases under different flow control
    send_random(400);
    drain();
    send_idle = 82;
    send_random(250);
    drain();
    send_idle  = 0;
    recv_stall = 82;
    send_random(250);
    drain();
    send_idle  = 14;
    recv_stall = 14;
    send_random(300);
    drain();
    send_idle  = 0;
    recv_stall = 0;
    send_random(250);
    drain();

    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
